// ----- rtl/x86alu_pkg.sv -----
// shared types and constants for the x86 integer alu
package x86alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_ADC  = 4'd1,
    OP_SUB  = 4'd2,
    OP_SBB  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_XOR  = 4'd6,
    OP_SHL  = 4'd7,
    OP_SHR  = 4'd8,
    OP_SAR  = 4'd9,
    OP_MUL  = 4'd10,
    OP_IMUL = 4'd11,
    OP_DIV  = 4'd12,
    OP_IDIV = 4'd13,
    OP_MOD  = 4'd14,
    OP_IMOD = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    SZ_8  = 2'd0,
    SZ_16 = 2'd1,
    SZ_32 = 2'd2,
    SZ_32B = 2'd3
  } size_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } alu_state_e;

  typedef struct packed {
    logic [63:0] result_value;
    logic        carry_flag;
    logic        parity_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
    logic        divide_error;
  } alu_res_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [63:0] src_operand;
    logic [63:0] dest_operand;
    logic [1:0]  size_code;
  } alu_req_t;

  localparam int unsigned DivSteps = 64;
  localparam int unsigned MulSteps = 4;

  // even parity of the low byte
  function automatic logic even_par(input logic [7:0] b);
    even_par = ~(^b);
  endfunction

endpackage

// ----- rtl/x86alu_if.sv -----
// valid/ready channel carrying one payload
interface x86alu_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/x86alu_fast.sv -----
// combinational add, sub, logic and shift path with flag generation
module x86alu_fast (
  input  x86alu_pkg::alu_req_t req_i,
  input  logic [4:0]           flags_i,
  output x86alu_pkg::alu_res_t res_o
);
  import x86alu_pkg::*;

  logic [31:0] s, d, r, mask, low, sh;
  logic [5:0]  bits;
  logic        cin, cf, of, sgn, big, zr;
  logic [32:0] sum;
  logic [63:0] wide;
  logic [5:0]  cnt;

  always_comb begin
    s    = req_i.src_operand[31:0];
    d    = req_i.dest_operand[31:0];
    cin  = flags_i[0];
    unique case (size_e'(req_i.size_code))
      SZ_8:    begin bits = 6'd8;  mask = 32'h0000_00ff; end
      SZ_16:   begin bits = 6'd16; mask = 32'h0000_ffff; end
      default: begin bits = 6'd32; mask = 32'hffff_ffff; end
    endcase
    r = '0; cf = 1'b0; of = 1'b0; sum = '0; low = '0; sh = '0; wide = '0;
    big = (s >= {26'd0, bits});
    cnt = s[5:0];
    sgn = |(d & mask & ~(mask >> 1));
    zr  = 1'b0;
    unique case (alu_op_e'(req_i.operation))
      OP_ADD, OP_ADC: begin
        sum = {1'b0, d} + {1'b0, s} + {32'd0, (req_i.operation == OP_ADC) & cin};
        r   = sum[31:0];
        cf  = sum[32];
        of  = (s[31] == d[31]) && (r[31] != s[31]);
      end
      OP_SUB, OP_SBB: begin
        sum = {1'b0, d} - {1'b0, s} - {32'd0, (req_i.operation == OP_SBB) & cin};
        r   = sum[31:0];
        cf  = sum[32];
        of  = (s[31] != d[31]) && (r[31] != d[31]);
      end
      OP_AND: r = s & d;
      OP_OR:  r = s | d;
      OP_XOR: r = s ^ d;
      default: begin
        // shifts on the sized part of the destination
        low = d & mask;
        of  = flags_i[4];
        if (s == 32'd0) begin
          cf = 1'b0;
        end else if (big) begin
          cf  = 1'b0;
          low = (req_i.operation == OP_SAR && sgn) ? mask : 32'd0;
        end else if (req_i.operation == OP_SHL) begin
          wide = {32'd0, low} << cnt;
          cf   = wide[bits];
          low  = wide[31:0] & mask;
        end else begin
          wide = {low, 32'd0} >> cnt;
          cf   = wide[31];
          low  = wide[63:32];
          sh   = mask & ~(mask >> cnt);
          if (req_i.operation == OP_SAR && sgn) low = low | sh;
        end
        r  = (d & ~mask) | low;
        zr = 1'b1;
      end
    endcase
    res_o.result_value  = {32'd0, r};
    res_o.carry_flag    = cf;
    res_o.parity_flag   = even_par(r[7:0]);
    res_o.zero_flag     = zr ? (low == 32'd0) : (r == 32'd0);
    res_o.sign_flag     = zr ? |(low & ~(mask >> 1) & mask) : r[31];
    res_o.overflow_flag = of;
    res_o.divide_error  = 1'b0;
  end
endmodule

// ----- rtl/x86_alu_with_flags.sv -----
// x86 integer alu with kept flags, top level
// One request is held at a time: ready drops at the accepting edge and comes back once the
// result register is loaded, so the next request can be taken in the same cycle as a result shows.
// Add, adc, sub, sbb, logic ops, shifts and a divide by zero go from dispatch straight to the
// result register. Mul and imul set up their operands, then run a 32x16 multiplier over 2
// passes of 16 bits each. Div, idiv, mod and imod use a shared restoring subtract unit,
// one quotient bit a cycle over 64 bits, then a sign fix step. The output register lets the
// result wait while the block is idle again; a result still waiting holds back the next one.
module x86_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  x86alu_if.sink      req_if,
  x86alu_if.source    res_if
);
  import x86alu_pkg::*;

  alu_state_e state_q, state_d;
  alu_req_t   req_q;
  alu_res_t   fast_res, res_q;
  logic [4:0] flags_q;
  logic       out_valid_q;
  logic       start_q;

  // mul datapath
  logic [31:0] ma_q, mb_q;
  logic [63:0] prod_q;
  logic [1:0]  mcnt_q;
  logic        mneg_q;

  // divide datapath
  logic [63:0] quo_q, rem_q, dvs_q;
  logic [6:0]  dcnt_q;
  logic        dn_q, sn_q;
  logic [64:0] trial;

  logic        take, deliver;
  logic [31:0] msk;
  logic [47:0] pp;
  logic [63:0] pshift, pfin, hi_part, dres;
  logic [5:0]  bits;

  x86alu_fast u_fast (.req_i(req_q), .flags_i(flags_q), .res_o(fast_res));

  assign req_if.ready = (state_q == ST_IDLE) && !start_q;
  assign take         = req_if.valid && req_if.ready;
  assign res_if.valid = out_valid_q;
  assign res_if.data  = res_q;
  assign deliver      = (state_q == ST_DONE) && !out_valid_q;

  // start flag: a request was latched and waits for dispatch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= 1'b0;
    else start_q <= take;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_q) begin
          unique case (alu_op_e'(req_q.operation))
            OP_MUL, OP_IMUL: state_d = ST_MUL;
            OP_DIV, OP_IDIV, OP_MOD, OP_IMOD:
              state_d = (req_q.src_operand == 64'd0) ? ST_DONE : ST_DIV;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MUL:  if (mcnt_q == 2'(MulSteps - 1)) state_d = ST_DONE;
      ST_DIV:  if (dcnt_q == 7'(DivSteps - 1)) state_d = ST_FIX;
      ST_FIX:  state_d = ST_DONE;
      ST_DONE: if (!out_valid_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (take) req_q <= req_if.data;
  end

  // size mask for mul
  always_comb begin
    unique case (size_e'(req_q.size_code))
      SZ_8:    begin msk = 32'h0000_00ff; bits = 6'd8;  end
      SZ_16:   begin msk = 32'h0000_ffff; bits = 6'd16; end
      default: begin msk = 32'hffff_ffff; bits = 6'd32; end
    endcase
  end

  // multiplier: magnitude times 16-bit slice, accumulate
  assign pp     = {16'd0, ma_q} * {32'd0, mb_q[15:0]};
  assign pshift = (mcnt_q == 2'd2) ? {pp[47:0], 16'd0} : {16'd0, pp};
  assign pfin   = mneg_q ? (64'd0 - prod_q) : prod_q;
  assign hi_part = (pfin >> bits) & {32'd0, msk};

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      mcnt_q <= '0;
      prod_q <= '0;
      if (req_q.operation == OP_IMUL) begin
        ma_q   <= req_q.src_operand[31] ? 32'd0 - req_q.src_operand[31:0]
                                        : req_q.src_operand[31:0];
        mb_q   <= req_q.dest_operand[31] ? 32'd0 - req_q.dest_operand[31:0]
                                         : req_q.dest_operand[31:0];
        mneg_q <= req_q.src_operand[31] ^ req_q.dest_operand[31];
      end else begin
        ma_q   <= req_q.src_operand[31:0] & msk;
        mb_q   <= req_q.dest_operand[31:0] & msk;
        mneg_q <= 1'b0;
      end
    end else if (state_q == ST_MUL) begin
      mcnt_q <= mcnt_q + 2'd1;
      // step 1 low slice, step 2 high slice
      if (mcnt_q == 2'd1) prod_q <= prod_q + pshift;
      if (mcnt_q == 2'd2) begin
        prod_q <= prod_q + pshift;
      end
      if (mcnt_q == 2'd1) mb_q <= {16'd0, mb_q[31:16]};
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      dcnt_q <= '0;
      rem_q  <= '0;
      dn_q   <= (req_q.operation == OP_IDIV || req_q.operation == OP_IMOD)
                && req_q.dest_operand[63];
      sn_q   <= (req_q.operation == OP_IDIV || req_q.operation == OP_IMOD)
                && req_q.src_operand[63];
      quo_q  <= ((req_q.operation == OP_IDIV || req_q.operation == OP_IMOD)
                 && req_q.dest_operand[63]) ? 64'd0 - req_q.dest_operand
                                            : req_q.dest_operand;
      dvs_q  <= ((req_q.operation == OP_IDIV || req_q.operation == OP_IMOD)
                 && req_q.src_operand[63]) ? 64'd0 - req_q.src_operand
                                           : req_q.src_operand;
    end else if (state_q == ST_DIV) begin
      dcnt_q <= dcnt_q + 7'd1;
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end else if (state_q == ST_FIX) begin
      if (dn_q ^ sn_q) quo_q <= 64'd0 - quo_q;
      if (dn_q) rem_q <= 64'd0 - rem_q;
    end
  end

  assign dres = (req_q.operation == OP_DIV || req_q.operation == OP_IDIV)
                ? {32'd0, quo_q[31:0]} : {32'd0, rem_q[31:0]};

  // result register and kept flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && res_if.ready) out_valid_q <= 1'b0;
      if (deliver) begin
        out_valid_q <= 1'b1;
        if (req_q.operation <= OP_SAR) begin
          flags_q <= {fast_res.overflow_flag, fast_res.sign_flag,
                      fast_res.zero_flag, fast_res.parity_flag,
                      fast_res.carry_flag};
        end else if (req_q.operation == OP_MUL) begin
          flags_q <= {hi_part != 64'd0, pfin[31], pfin[31:0] == 32'd0,
                      even_par(pfin[7:0]), hi_part != 64'd0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (deliver) begin
      priority if (req_q.operation <= OP_SAR) begin
        res_q <= fast_res;
      end else if (req_q.operation == OP_MUL) begin
        res_q <= '{pfin, hi_part != 64'd0, even_par(pfin[7:0]),
                   pfin[31:0] == 32'd0, pfin[31], hi_part != 64'd0, 1'b0};
      end else if (req_q.operation == OP_IMUL) begin
        res_q <= '{pfin, flags_q[0], flags_q[1], flags_q[2], flags_q[3],
                   flags_q[4], 1'b0};
      end else begin
        res_q <= '{(req_q.src_operand == 64'd0) ? 64'd0 : dres,
                   flags_q[0], flags_q[1], flags_q[2], flags_q[3], flags_q[4],
                   req_q.src_operand == 64'd0};
      end
    end
  end
endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the x86 integer alu with kept flags
`timescale 1ns / 1ps

module testbench;
  import x86alu_pkg::*;

  // flag prediction and the store of expected results
  class alu_scoreboard;
    logic [4:0] kept_flags;
    alu_res_t   pending_results[$];
    int         mismatch_count;

    function new();
      kept_flags = '0;
      mismatch_count = 0;
    endfunction

    function logic low_parity(input logic [63:0] v);
      low_parity = ~(^v[7:0]);
    endfunction

    // work out the result of one accepted request
    function void note_request(input alu_req_t req);
      logic [31:0] s, d, r, mask, low;
      logic [63:0] s64, d64, prod, ua, ub, v;
      logic [32:0] wide;
      logic        cin, cf, of, sgn, dn, sn;
      int unsigned bits;
      alu_res_t    res;
      s64 = req.src_operand;
      d64 = req.dest_operand;
      s = s64[31:0];
      d = d64[31:0];
      cin = kept_flags[0];
      bits = (req.size_code == SZ_8) ? 8 : (req.size_code == SZ_16) ? 16 : 32;
      mask = (bits == 8) ? 32'hff : (bits == 16) ? 32'hffff : 32'hffffffff;
      res = '0;
      case (alu_op_e'(req.operation))
        OP_ADD, OP_ADC: begin
          wide = {1'b0, d} + {1'b0, s} + ((req.operation == OP_ADC) ? cin : 1'b0);
          r = wide[31:0];
          of = (s[31] == d[31]) && (r[31] != s[31]);
          kept_flags = {of, r[31], r == 0, low_parity({32'h0, r}), wide[32]};
          res.result_value = {32'h0, r};
        end
        OP_SUB, OP_SBB: begin
          wide = {1'b0, d} - {1'b0, s} - ((req.operation == OP_SBB) ? cin : 1'b0);
          r = wide[31:0];
          of = (s[31] != d[31]) && (r[31] != d[31]);
          kept_flags = {of, r[31], r == 0, low_parity({32'h0, r}), wide[32]};
          res.result_value = {32'h0, r};
        end
        OP_AND, OP_OR, OP_XOR: begin
          r = (req.operation == OP_AND) ? (s & d) : (req.operation == OP_OR) ? (s | d) : (s ^ d);
          kept_flags = {1'b0, r[31], r == 0, low_parity({32'h0, r}), 1'b0};
          res.result_value = {32'h0, r};
        end
        OP_SHL, OP_SHR, OP_SAR: begin
          low = d & mask;
          sgn = low[bits-1];
          cf = 1'b0;
          if (s == 0) begin
          end else if (s >= bits) begin
            low = (req.operation == OP_SAR && sgn) ? mask : 32'h0;
          end else if (req.operation == OP_SHL) begin
            cf = low[bits-s];
            low = (low << s) & mask;
          end else begin
            cf = low[s-1];
            low = low >> s;
            if (req.operation == OP_SAR && sgn) low = low | (mask & ~(mask >> s));
          end
          r = (d & ~mask) | low;
          kept_flags = {kept_flags[4], low[bits-1], low == 0, low_parity({32'h0, r}), cf};
          res.result_value = {32'h0, r};
        end
        OP_MUL: begin
          prod = {32'h0, s & mask} * {32'h0, d & mask};
          cf = ((prod >> bits) & {32'h0, mask}) != 0;
          kept_flags = {cf, prod[31], prod[31:0] == 0, low_parity(prod), cf};
          res.result_value = prod;
        end
        OP_IMUL: begin
          prod = $signed({{32{s[31]}}, s}) * $signed({{32{d[31]}}, d});
          res.result_value = prod;
        end
        default: begin
          if (s64 == 0) begin
            res.divide_error = 1'b1;
          end else if (req.operation == OP_DIV) begin
            res.result_value = (d64 / s64) & 64'hffffffff;
          end else if (req.operation == OP_MOD) begin
            res.result_value = (d64 % s64) & 64'hffffffff;
          end else begin
            dn = d64[63];
            sn = s64[63];
            ua = dn ? -d64 : d64;
            ub = sn ? -s64 : s64;
            if (req.operation == OP_IDIV) begin
              v = ua / ub;
              if (dn != sn) v = -v;
            end else begin
              v = ua % ub;
              if (dn) v = -v;
            end
            res.result_value = v & 64'hffffffff;
          end
        end
      endcase
      res.carry_flag = kept_flags[0];
      res.parity_flag = kept_flags[1];
      res.zero_flag = kept_flags[2];
      res.sign_flag = kept_flags[3];
      res.overflow_flag = kept_flags[4];
      pending_results.push_back(res);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(input alu_res_t got);
      alu_res_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;

  x86alu_if #(.payload_t(alu_req_t)) req_if ();
  x86alu_if #(.payload_t(alu_res_t)) res_if ();

  x86_alu_with_flags i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if.sink),
    .res_if (res_if.source)
  );

  alu_scoreboard alu_sb = new();

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // result side: random stalls, sample at rising edge
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) alu_sb.check_result(res_if.data);
  end

  // send one request, with random idle gaps
  task automatic send_request(input alu_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    alu_sb.note_request(req);
    @(negedge clk_i);
  endtask

  task automatic send_op(input alu_op_e op, input logic [63:0] src, input logic [63:0] dst,
                         input size_e sz);
    alu_req_t req;
    req.operation = op;
    req.src_operand = src;
    req.dest_operand = dst;
    req.size_code = sz;
    send_request(req);
  endtask

  function automatic logic [63:0] rand64();
    rand64 = {$urandom(), $urandom()};
  endfunction

  // random request, shaped toward edge cases
  task automatic send_random();
    alu_req_t req;
    req.operation = 4'($urandom_range(15));
    req.size_code = 2'($urandom_range(3));
    req.src_operand = rand64();
    req.dest_operand = rand64();
    case ($urandom_range(7))
      0: req.src_operand = 64'($urandom_range(40));
      1: req.src_operand = '0;
      2: req.dest_operand = {32'h0, $urandom_range(3) == 0 ? 32'h80000000 : 32'hffffffff};
      3: req.src_operand = {{32{1'b1}}, $urandom()};
      default: ;
    endcase
    if (req.operation >= OP_DIV && $urandom_range(3) == 0)
      req.src_operand = 64'($urandom_range(255));
    send_request(req);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (alu_sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    int k;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part
    send_idle_pct = 9;
    recv_idle_pct = 76;
    send_op(OP_ADD, 64'hffffffff, 64'h1, SZ_32);
    send_op(OP_ADC, 64'h0, 64'hffffffff, SZ_32);
    send_op(OP_ADD, 64'h7fffffff, 64'h1, SZ_32);
    send_op(OP_SUB, 64'h1, 64'h0, SZ_32);
    send_op(OP_SBB, 64'hffffffff, 64'hffffffff, SZ_32);
    send_op(OP_AND, 64'hffffffffffffffff, 64'h80000000, SZ_32);
    send_op(OP_OR, 64'h0, 64'h0, SZ_8);
    send_op(OP_XOR, 64'h5a5a5a5a, 64'ha5a5a5a5, SZ_16);
    send_op(OP_SHL, 64'h0, 64'h12345681, SZ_8);
    send_op(OP_SHL, 64'h1, 64'h12345681, SZ_8);
    send_op(OP_SHR, 64'h10, 64'h8001, SZ_16);
    send_op(OP_SAR, 64'h100000000, 64'h80000000, SZ_32);
    send_op(OP_SAR, 64'h3, 64'hf0, SZ_8);
    send_op(OP_SHR, 64'h1f, 64'hffffffff, SZ_32B);
    send_op(OP_MUL, 64'hffffffff, 64'hffffffff, SZ_32);
    send_op(OP_MUL, 64'hff, 64'hff, SZ_8);
    send_op(OP_IMUL, 64'hffffffff, 64'h80000000, SZ_32);
    send_op(OP_DIV, 64'h0, 64'h1234, SZ_32);
    send_op(OP_DIV, 64'h3, 64'hffffffffffffffff, SZ_32);
    send_op(OP_IDIV, 64'hffffffffffffffff, 64'h8000000000000000, SZ_32);
    send_op(OP_IMOD, 64'hffffffffffffffff, 64'h8000000000000000, SZ_32);
    send_op(OP_IDIV, 64'h7, 64'hffffffffffffff9c, SZ_32);
    send_op(OP_MOD, 64'h8000000000000000, 64'hffffffffffffffff, SZ_32);
    send_op(OP_IMOD, 64'h0, 64'h5, SZ_32);

    // sender holds off until everything has drained
    wait_drained();

    // random part over three idling phases
    for (k = 0; k < 700; k++) begin
      if (k == 233) begin
        send_idle_pct = 76;
        recv_idle_pct = 9;
      end else if (k == 466) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random();
    end
    wait_drained();
    if (alu_sb.mismatch_count == 0 && alu_sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
